### hw/rtl/bqc_pkg.sv
// ---------------------------------------------------------------------------
// Biquad coefficient calculator package
// Shared beat types, fixed constants and small helper functions.
// ---------------------------------------------------------------------------
package bqc_pkg;

  localparam int SR_W   = 18;
  localparam int CUT_W  = 17;
  localparam int QUAL_W = 16;
  localparam int GAIN_W = 16;
  localparam int COEF_W = 32;
  localparam int CX_W   = 34;

  localparam logic [SR_W-1:0]   SR_RESET = 18'd48000;
  localparam logic [31:0]       PI_Q30   = 32'hC90F_DAA2;
  localparam logic [CX_W-1:0]   CORDIC_K = 34'h0_26DD_3B6A;

  typedef struct packed {
    logic              action;
    logic [CUT_W-1:0]  cutoff_hz;
    logic [QUAL_W-1:0] quality;
    logic [GAIN_W-1:0] peak_gain;
  } bqc_in_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_b0;
    logic signed [COEF_W-1:0] coef_b1;
    logic signed [COEF_W-1:0] coef_b2;
    logic signed [COEF_W-1:0] coef_a1;
    logic signed [COEF_W-1:0] coef_a2;
    logic                     clamped;
  } bqc_out_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] val;
    unique case (idx)
      5'd0:    val = 32'h3243_F6A9;
      5'd1:    val = 32'h1DAC_6705;
      5'd2:    val = 32'h0FAD_BAFD;
      5'd3:    val = 32'h07F5_6EA7;
      5'd4:    val = 32'h03FE_AB77;
      5'd5:    val = 32'h01FF_D55C;
      5'd6:    val = 32'h00FF_FAAB;
      5'd7:    val = 32'h007F_FF55;
      5'd8:    val = 32'h003F_FFEB;
      5'd9:    val = 32'h001F_FFFD;
      5'd31:   val = 32'h0000_0000;
      default: val = 32'd1 << (5'd30 - idx);
    endcase
    return val;
  endfunction

  // Returns the overflow flag above the saturated two's complement word.
  function automatic logic [32:0] sat_q(input logic [63:0] mag, input logic neg);
    logic [32:0] res;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        res = {1'b1, 32'h8000_0000};
      end else begin
        res = {1'b0, 32'(64'd0 - mag)};
      end
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) begin
        res = {1'b1, 32'h7FFF_FFFF};
      end else begin
        res = {1'b0, mag[31:0]};
      end
    end
    return res;
  endfunction

endpackage

### hw/rtl/bqc_div_cell.sv
// ---------------------------------------------------------------------------
// Restoring division cell
// Produces one quotient bit per beat and hands the partial remainder on.
// ---------------------------------------------------------------------------
module bqc_div_cell
  import bqc_pkg::*;
#(
  parameter int DW = 18,
  parameter int QW = 32,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [DW:0]   rem_i,
  input  logic [DW-1:0] dvs_i,
  input  logic [QW-1:0] quo_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [DW:0]   rem_o,
  output logic [DW-1:0] dvs_o,
  output logic [QW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  logic          ge;
  logic [DW:0]   diff;
  logic          vld_r;
  logic [DW:0]   rem_r,  rem_nxt;
  logic [DW-1:0] dvs_r;
  logic [QW-1:0] quo_r,  quo_nxt;
  logic [TW-1:0] tag_r;

  always_comb begin
    ge      = rem_i >= {1'b0, dvs_i};
    diff    = ge ? (rem_i - {1'b0, dvs_i}) : rem_i;
    rem_nxt = {diff[DW-1:0], 1'b0};
    quo_nxt = {quo_i[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      dvs_r <= dvs_i;
      quo_r <= quo_nxt;
      tag_r <= tag_i;
    end
  end

  assign vld_o = vld_r;
  assign rem_o = rem_r;
  assign dvs_o = dvs_r;
  assign quo_o = quo_r;
  assign tag_o = tag_r;

endmodule

### hw/rtl/bqc_div_chain.sv
// ---------------------------------------------------------------------------
// Division chain
// A row of division cells giving floor(rem * 2^(QW-1) / dvs), rem < 2*dvs.
// ---------------------------------------------------------------------------
module bqc_div_chain
  import bqc_pkg::*;
#(
  parameter int DW = 18,
  parameter int QW = 32,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [DW:0]   rem_i,
  input  logic [DW-1:0] dvs_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [QW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  logic          vld_w [0:QW];
  logic [DW:0]   rem_w [0:QW];
  logic [DW-1:0] dvs_w [0:QW];
  logic [QW-1:0] quo_w [0:QW];
  logic [TW-1:0] tag_w [0:QW];

  assign vld_w[0] = vld_i;
  assign rem_w[0] = rem_i;
  assign dvs_w[0] = dvs_i;
  assign quo_w[0] = '0;
  assign tag_w[0] = tag_i;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    bqc_div_cell #(.DW(DW), .QW(QW), .TW(TW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (vld_w[k]),
      .rem_i (rem_w[k]),
      .dvs_i (dvs_w[k]),
      .quo_i (quo_w[k]),
      .tag_i (tag_w[k]),
      .vld_o (vld_w[k+1]),
      .rem_o (rem_w[k+1]),
      .dvs_o (dvs_w[k+1]),
      .quo_o (quo_w[k+1]),
      .tag_o (tag_w[k+1])
    );
  end

  assign vld_o = vld_w[QW];
  assign quo_o = quo_w[QW];
  assign tag_o = tag_w[QW];

endmodule

### hw/rtl/bqc_cordic_cell.sv
// ---------------------------------------------------------------------------
// CORDIC rotation cell
// One micro-rotation of the sine and cosine vector per beat.
// ---------------------------------------------------------------------------
module bqc_cordic_cell
  import bqc_pkg::*;
#(
  parameter int STAGE = 0,
  parameter int TW    = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   vld_i,
  input  logic signed [CX_W-1:0] x_i,
  input  logic signed [CX_W-1:0] y_i,
  input  logic signed [CX_W-1:0] z_i,
  input  logic [TW-1:0]          tag_i,
  output logic                   vld_o,
  output logic signed [CX_W-1:0] x_o,
  output logic signed [CX_W-1:0] y_o,
  output logic signed [CX_W-1:0] z_o,
  output logic [TW-1:0]          tag_o
);

  logic signed [CX_W-1:0] xs, ys, ang;
  logic                   vld_r;
  logic signed [CX_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [TW-1:0]          tag_r;

  always_comb begin
    xs  = x_i >>> STAGE;
    ys  = y_i >>> STAGE;
    ang = $signed({2'b00, atan_q30(5'(STAGE))});
    if (!z_i[CX_W-1]) begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ang;
    end else begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      tag_r <= tag_i;
    end
  end

  assign vld_o = vld_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign tag_o = tag_r;

endmodule

### hw/rtl/biquad_coefficient_calculator_top.sv
// ---------------------------------------------------------------------------
// Biquad coefficient calculator
// Lowpass and highpass cookbook coefficients in signed fixed point.
// ---------------------------------------------------------------------------
// The block takes one request every cycle unless in_stall is high and
// returns one coefficient set per request, in order. The pipeline is made
// of the cell rows: 32 cells for the phase division, one cell per CORDIC
// stage, 38 cells for the alpha division and COEF_FRAC_BITS + 6 cells for
// the coefficient divisions, plus five pipeline registers. A stall on the
// result side holds the whole pipeline.
// ---------------------------------------------------------------------------
module biquad_coefficient_calculator_top
  import bqc_pkg::*;
#(
  parameter int CORDIC_STAGES  = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [SR_W-1:0] cfg_wr_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  bqc_in_t         in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output bqc_out_t        out_data
);

  localparam int PH_QW = 32;
  localparam int AL_QW = 38;
  localparam int AL_DW = QUAL_W + AL_QW - 1;
  localparam int A0_W  = AL_QW + 1;
  localparam int BD_W  = A0_W + 16;
  localparam int AD_W  = A0_W + 4;
  localparam int CQ_W  = COEF_FRAC_BITS + 6;
  localparam int N1_W  = 47;
  localparam int T1_W  = 1 + QUAL_W + GAIN_W + 1;
  localparam int T2_W  = T1_W + 1;
  localparam int T3_W  = 1 + GAIN_W + 1 + 32;

  localparam logic signed [CX_W-1:0] ONE_X = 34'sd1073741824;

  logic                  en;
  logic [SR_W-1:0]       sr_r;

  // Request decode
  logic [SR_W-1:0]       sr_eff, cut2, cut2_in;
  logic [QUAL_W-1:0]     q_eff;
  logic                  clamp_in;

  logic                  ph_vld;
  logic [PH_QW-1:0]      ph_quo;
  logic [T1_W-1:0]       ph_tag;

  logic [PH_QW-1:0]      turn;
  logic                  mirror;
  logic                  s1_vld_r;
  logic [30:0]           s1_turn_r, s1_turn_nxt;
  logic [T2_W-1:0]       s1_tag_r;

  logic                  s2_vld_r;
  logic [62:0]           s2_prod_r;
  logic [T2_W-1:0]       s2_tag_r;
  logic [62:0]           theta_sum;

  logic                   cd_vld [0:CORDIC_STAGES];
  logic signed [CX_W-1:0] cd_x   [0:CORDIC_STAGES];
  logic signed [CX_W-1:0] cd_y   [0:CORDIC_STAGES];
  logic signed [CX_W-1:0] cd_z   [0:CORDIC_STAGES];
  logic [T2_W-1:0]        cd_tag [0:CORDIC_STAGES];

  logic signed [CX_W-1:0] x_cl;
  logic signed [31:0]     c_nxt;
  logic [30:0]            s_nxt;
  logic                   s4_vld_r;
  logic [30:0]            s4_s_r;
  logic signed [31:0]     s4_c_r;
  logic [T1_W-1:0]        s4_tag_r;

  logic [AL_QW-1:0]      al_num;
  logic                  al_vld;
  logic [AL_QW-1:0]      al_quo;
  logic [T3_W-1:0]       al_tag;

  logic                  t_action, t_clamp;
  logic [GAIN_W-1:0]     t_gain;
  logic signed [31:0]    t_c;
  logic signed [32:0]    num_b;
  logic [30:0]           c_abs;

  logic                  s5_vld_r;
  logic [A0_W-1:0]       s5_a0_r;
  logic [N1_W-1:0]       s5_n1_r;
  logic [31:0]           s5_n2_r;
  logic [A0_W-1:0]       s5_nn_r, nn_nxt;
  logic                  s5_clamp_r, s5_action_r, s5_a1neg_r, s5_a2neg_r;

  logic                  b_vld, a1_vld, a2_vld;
  logic [CQ_W-1:0]       b_quo, a1_quo, a2_quo;
  logic [1:0]            b_tag;
  logic                  a1_tag, a2_tag;

  logic [CQ_W:0]         b0_mag, b1_mag, a1_mag, a2_mag;
  logic [32:0]           b0_s, b1_s, a1_s, a2_s;

  logic                  out_vld_r;
  bqc_out_t              out_data_r, out_data_nxt;

  assign en       = !(out_vld_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r <= SR_RESET;
    end else if (cfg_wr_en) begin
      sr_r <= cfg_wr_data;
    end
  end

  always_comb begin
    sr_eff   = (sr_r == '0) ? SR_W'(1) : sr_r;
    q_eff    = (in_data.quality == '0) ? QUAL_W'(1) : in_data.quality;
    cut2     = {in_data.cutoff_hz, 1'b0};
    clamp_in = cut2 > sr_eff;
    cut2_in  = clamp_in ? '0 : cut2;
  end

  bqc_div_chain #(.DW(SR_W), .QW(PH_QW), .TW(T1_W)) u_phase_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_valid),
    .rem_i ({1'b0, cut2_in}),
    .dvs_i (sr_eff),
    .tag_i ({in_data.action, q_eff, in_data.peak_gain, clamp_in}),
    .vld_o (ph_vld),
    .quo_o (ph_quo),
    .tag_o (ph_tag)
  );

  always_comb begin
    turn   = ph_tag[0] ? 32'h8000_0000 : ph_quo;
    mirror = turn > 32'h4000_0000;
    s1_turn_nxt = mirror ? 31'(32'h8000_0000 - turn) : turn[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= ph_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_turn_r <= s1_turn_nxt;
      s1_tag_r  <= {ph_tag, mirror};
      s2_prod_r <= 63'(s1_turn_r) * 63'(PI_Q30);
      s2_tag_r  <= s1_tag_r;
    end
  end

  assign theta_sum = s2_prod_r + 63'h4000_0000;

  assign cd_vld[0] = s2_vld_r;
  assign cd_x[0]   = CORDIC_K;
  assign cd_y[0]   = '0;
  assign cd_z[0]   = $signed({2'b00, theta_sum[62:31]});
  assign cd_tag[0] = s2_tag_r;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    bqc_cordic_cell #(.STAGE(k), .TW(T2_W)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (cd_vld[k]),
      .x_i   (cd_x[k]),
      .y_i   (cd_y[k]),
      .z_i   (cd_z[k]),
      .tag_i (cd_tag[k]),
      .vld_o (cd_vld[k+1]),
      .x_o   (cd_x[k+1]),
      .y_o   (cd_y[k+1]),
      .z_o   (cd_z[k+1]),
      .tag_o (cd_tag[k+1])
    );
  end

  always_comb begin
    if (cd_x[CORDIC_STAGES] > ONE_X) begin
      x_cl = ONE_X;
    end else if (cd_x[CORDIC_STAGES] < -ONE_X) begin
      x_cl = -ONE_X;
    end else begin
      x_cl = cd_x[CORDIC_STAGES];
    end
    c_nxt = cd_tag[CORDIC_STAGES][0] ? -(32'(x_cl)) : 32'(x_cl);
    if (cd_y[CORDIC_STAGES] > ONE_X) begin
      s_nxt = 31'h4000_0000;
    end else if (cd_y[CORDIC_STAGES][CX_W-1]) begin
      s_nxt = '0;
    end else begin
      s_nxt = cd_y[CORDIC_STAGES][30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= cd_vld[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_s_r   <= s_nxt;
      s4_c_r   <= c_nxt;
      s4_tag_r <= cd_tag[CORDIC_STAGES][T2_W-1:1];
    end
  end

  assign al_num = AL_QW'({s4_s_r, 7'b0}) + AL_QW'(s4_tag_r[T1_W-2 -: QUAL_W] >> 1);

  bqc_div_chain #(.DW(AL_DW), .QW(AL_QW), .TW(T3_W)) u_alpha_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (s4_vld_r),
    .rem_i ((AL_DW + 1)'(al_num)),
    .dvs_i ({s4_tag_r[T1_W-2 -: QUAL_W], {(AL_QW - 1){1'b0}}}),
    .tag_i ({s4_tag_r[T1_W-1], s4_tag_r[GAIN_W:1], s4_tag_r[0], s4_c_r}),
    .vld_o (al_vld),
    .quo_o (al_quo),
    .tag_o (al_tag)
  );

  always_comb begin
    t_action = al_tag[T3_W-1];
    t_gain   = al_tag[T3_W-2 -: GAIN_W];
    t_clamp  = al_tag[32];
    t_c      = $signed(al_tag[31:0]);
    num_b    = t_action ? (33'sh0_4000_0000 + 33'(t_c)) : (33'sh0_4000_0000 - 33'(t_c));
    c_abs    = t_c[31] ? 31'(-t_c) : t_c[30:0];
    if (al_quo > AL_QW'(32'h4000_0000)) begin
      nn_nxt = A0_W'(al_quo) - A0_W'(32'h4000_0000);
    end else begin
      nn_nxt = A0_W'(32'h4000_0000) - A0_W'(al_quo);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= al_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_a0_r     <= A0_W'(al_quo) + A0_W'(32'h4000_0000);
      s5_n1_r     <= N1_W'(num_b[31:0]) * N1_W'(t_gain);
      s5_n2_r     <= {c_abs, 1'b0};
      s5_nn_r     <= nn_nxt;
      s5_clamp_r  <= t_clamp;
      s5_action_r <= t_action;
      s5_a1neg_r  <= !t_c[31] && (t_c != '0);
      s5_a2neg_r  <= al_quo > AL_QW'(32'h4000_0000);
    end
  end

  bqc_div_chain #(.DW(BD_W), .QW(CQ_W), .TW(2)) u_b_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (s5_vld_r),
    .rem_i ((BD_W + 1)'(s5_n1_r)),
    .dvs_i ({s5_a0_r, 16'b0}),
    .tag_i ({s5_clamp_r, s5_action_r}),
    .vld_o (b_vld),
    .quo_o (b_quo),
    .tag_o (b_tag)
  );

  bqc_div_chain #(.DW(AD_W), .QW(CQ_W), .TW(1)) u_a1_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (s5_vld_r),
    .rem_i ((AD_W + 1)'(s5_n2_r)),
    .dvs_i ({s5_a0_r, 4'b0}),
    .tag_i (s5_a1neg_r),
    .vld_o (a1_vld),
    .quo_o (a1_quo),
    .tag_o (a1_tag)
  );

  bqc_div_chain #(.DW(AD_W), .QW(CQ_W), .TW(1)) u_a2_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (s5_vld_r),
    .rem_i ((AD_W + 1)'(s5_nn_r)),
    .dvs_i ({s5_a0_r, 4'b0}),
    .tag_i (s5_a2neg_r),
    .vld_o (a2_vld),
    .quo_o (a2_quo),
    .tag_o (a2_tag)
  );

  always_comb begin
    b0_mag = ((CQ_W + 1)'(b_quo >> 1) + (CQ_W + 1)'(1)) >> 1;
    b1_mag = ((CQ_W + 1)'(b_quo) + (CQ_W + 1)'(1)) >> 1;
    a1_mag = ((CQ_W + 1)'(a1_quo) + (CQ_W + 1)'(1)) >> 1;
    a2_mag = ((CQ_W + 1)'(a2_quo) + (CQ_W + 1)'(1)) >> 1;
    b0_s   = sat_q(64'(b0_mag), 1'b0);
    b1_s   = sat_q(64'(b1_mag), b_tag[0]);
    a1_s   = sat_q(64'(a1_mag), a1_tag);
    a2_s   = sat_q(64'(a2_mag), a2_tag);
    out_data_nxt.coef_b0 = $signed(b0_s[31:0]);
    out_data_nxt.coef_b1 = $signed(b1_s[31:0]);
    out_data_nxt.coef_b2 = $signed(b0_s[31:0]);
    out_data_nxt.coef_a1 = $signed(a1_s[31:0]);
    out_data_nxt.coef_a2 = $signed(a2_s[31:0]);
    out_data_nxt.clamped = b_tag[1] | b0_s[32] | b1_s[32] | a1_s[32] | a2_s[32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= b_vld & a1_vld & a2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while a result beat is stalled");

  a_b2_matches_b0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.coef_b2 == out_data.coef_b0)
    else $error("b2 differs from b0");

  a_turn_folded: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> s1_turn_r <= 31'h4000_0000)
    else $error("phase not folded into the first quadrant");

  a_a0_floor: assert property (@(posedge clk) disable iff (!rst_n)
    s5_vld_r |-> s5_a0_r >= A0_W'(32'h4000_0000))
    else $error("a0 below one");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (b_vld == a1_vld) && (b_vld == a2_vld))
    else $error("coefficient division rows out of step");

endmodule
